// ===== rtl/lfr_pkg.sv =====
// Shared types, sizes and language tables for the letter frequency ranker.
// Used by the histogram, the sorting cells and the top level.
// No dependencies.
package lfr_pkg;

  localparam int ALPHABET   = 26;
  localparam int COUNT_BITS = 16;
  localparam int LETTER_W   = 5;
  localparam int IDX_W      = $clog2(ALPHABET);
  localparam int TABLE_LEN  = 26;
  localparam int PADDR_W    = 3;

  // Register byte addresses, decoded on the word index bits.
  localparam logic REG_LANGUAGE = 1'b0;

  // One histogram entry travelling through the sorting chain.
  typedef struct packed {
    logic                  vld;
    logic [COUNT_BITS-1:0] cnt;
    logic [LETTER_W-1:0]   ltr;
  } lfr_item_t;

  typedef enum logic [3:0] {
    S_COUNT  = 4'b0001,
    S_DUMP   = 4'b0010,
    S_SETTLE = 4'b0100,
    S_EMIT   = 4'b1000
  } lfr_state_t;

  localparam logic [LETTER_W-1:0] EN_TABLE [TABLE_LEN] = '{
    5'd4, 5'd19, 5'd0, 5'd14, 5'd8, 5'd13, 5'd18, 5'd7, 5'd17, 5'd3, 5'd11, 5'd2, 5'd20,
    5'd12, 5'd22, 5'd5, 5'd6, 5'd24, 5'd15, 5'd1, 5'd21, 5'd10, 5'd9, 5'd23, 5'd16, 5'd25
  };
  localparam logic [LETTER_W-1:0] PT_TABLE [TABLE_LEN] = '{
    5'd0, 5'd4, 5'd14, 5'd18, 5'd17, 5'd8, 5'd13, 5'd3, 5'd12, 5'd20, 5'd19, 5'd2, 5'd11,
    5'd15, 5'd21, 5'd6, 5'd7, 5'd16, 5'd1, 5'd5, 5'd25, 5'd9, 5'd23, 5'd10, 5'd24, 5'd22
  };

  // Reference-language letter at a given rank; ranks past the table give 0.
  function automatic logic [LETTER_W-1:0] guess_of(input logic lang,
                                                   input logic [LETTER_W-1:0] r);
    logic [LETTER_W-1:0] g;
    g = '0;
    if (int'(r) < TABLE_LEN) begin
      g = lang ? PT_TABLE[r] : EN_TABLE[r];
    end
    return g;
  endfunction

  // Ordering of the ranking: larger count first, then higher letter first.
  function automatic logic ranks_above(input lfr_item_t a, input lfr_item_t b);
    return (a.cnt > b.cnt) || ((a.cnt == b.cnt) && (a.ltr > b.ltr));
  endfunction

endpackage

// ===== rtl/lfr_hist.sv =====
// Letter histogram: one saturating counter per letter.
// During unload the counters shift toward entry 0, filling zeros behind.
// Depends on lfr_pkg.
module lfr_hist (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          inc_en,
  input  logic [lfr_pkg::LETTER_W-1:0]  inc_letter,
  input  logic                          shift_en,
  output logic [lfr_pkg::COUNT_BITS-1:0] head_cnt
);
  import lfr_pkg::*;

  logic [COUNT_BITS-1:0] cnt [ALPHABET];

  for (genvar j = 0; j < ALPHABET; j++) begin : g_ctr
    logic [COUNT_BITS-1:0] from_right;

    if (j == ALPHABET - 1) begin : g_tail
      assign from_right = '0;
    end else begin : g_body
      assign from_right = cnt[j+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cnt[j] <= '0;
      end else if (shift_en) begin
        cnt[j] <= from_right;
      end else if (inc_en && (inc_letter == LETTER_W'(j)) && (cnt[j] != '1)) begin
        cnt[j] <= cnt[j] + COUNT_BITS'(1);
      end
    end
  end

  assign head_cnt = cnt[0];

endmodule

// ===== rtl/lfr_sort_cell.sv =====
// One cell of the insertion-sort chain: keeps the better of its held entry
// and the arriving one, passes the other right; shifts left while unloading.
// Depends on lfr_pkg.
module lfr_sort_cell (
  input  logic               clk,
  input  logic               rst,
  input  lfr_pkg::lfr_item_t ins_in,
  input  logic               shift_en,
  input  lfr_pkg::lfr_item_t shift_in,
  output lfr_pkg::lfr_item_t held,
  output lfr_pkg::lfr_item_t pass_out
);
  import lfr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      pass_out <= '0;
    end else if (shift_en) begin
      held         <= shift_in;
      pass_out.vld <= 1'b0;
    end else if (ins_in.vld) begin
      if (!held.vld) begin
        held         <= ins_in;
        pass_out.vld <= 1'b0;
      end else if (ranks_above(ins_in, held)) begin
        held     <= ins_in;
        pass_out <= held;
      end else begin
        pass_out <= ins_in;
      end
    end else begin
      pass_out.vld <= 1'b0;
    end
  end

endmodule

// ===== rtl/letter_frequency_ranker_unit.sv =====
// Letter frequency ranker: histogram, insertion-sort cell chain and control.
// Depends on lfr_pkg, lfr_hist and lfr_sort_cell.
//
// Usage: letters arrive on the input channel (letter, last) with in_valid /
// in_ready, one request per cycle while counting. Letters above z are ignored
// but a last flag on them still starts the ranking. After the request with
// last set, in_ready stays low until the whole ranking has been taken.
// Ranking: the histogram is unloaded into a chain of 26 sort cells, one
// letter a cycle, then the chain settles in the settle state before the
// first result is shown.
// Results follow one per cycle, most frequent first, while out_ready is high;
// a stall simply holds the head result and the chain. The counters and the
// total are clear again when the final result (last_of_run) is taken.
// The language register (APB, address 0, bit 0) selects the guess table:
// 0 English, 1 Portuguese. Reset clears the histogram, the total, the chain
// and the register, and leaves the block ready for letters.
module letter_frequency_ranker_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lfr_pkg::LETTER_W-1:0]      letter,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lfr_pkg::LETTER_W-1:0]      rank,
  output logic [lfr_pkg::LETTER_W-1:0]      ranked_letter,
  output logic [lfr_pkg::COUNT_BITS-1:0]    count,
  output logic [lfr_pkg::COUNT_BITS-1:0]    total,
  output logic [lfr_pkg::LETTER_W-1:0]      guess_letter,
  output logic                              last_of_run,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lfr_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import lfr_pkg::*;

  lfr_state_t            state, state_next;
  logic [IDX_W-1:0]      step;
  logic [COUNT_BITS-1:0] letter_total;
  logic                  language;

  logic                  in_fire, out_fire, in_range, step_end;
  logic [COUNT_BITS-1:0] hist_head;
  lfr_item_t             dump_item;
  lfr_item_t             held [ALPHABET];
  lfr_item_t             pass [ALPHABET+1];
  lfr_item_t             from_right [ALPHABET];

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      language <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_LANGUAGE)) begin
      language <= pwdata[0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_LANGUAGE) ? {31'b0, language} : 32'b0;

  // Control.
  assign in_ready  = (state == S_COUNT);
  assign out_valid = (state == S_EMIT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign in_range  = ({1'b0, letter} < (LETTER_W+1)'(ALPHABET));
  assign step_end  = (step == IDX_W'(ALPHABET - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_COUNT:  if (in_fire && last) state_next = S_DUMP;
      S_DUMP:   if (step_end) state_next = S_SETTLE;
      S_SETTLE: if (step_end) state_next = S_EMIT;
      S_EMIT:   if (out_fire && step_end) state_next = S_COUNT;
      default:  state_next = S_COUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COUNT;
      step  <= '0;
    end else begin
      state <= state_next;
      if ((state == S_DUMP) || (state == S_SETTLE) || out_fire) begin
        step <= step_end ? '0 : step + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_total <= '0;
    end else if (out_fire && step_end) begin
      letter_total <= '0;
    end else if (in_fire && in_range && (letter_total != '1)) begin
      letter_total <= letter_total + COUNT_BITS'(1);
    end
  end

  // Histogram, unloaded one letter per cycle into the sort chain.
  lfr_hist u_hist (
    .clk        (clk),
    .rst        (rst),
    .inc_en     (in_fire),
    .inc_letter (letter),
    .shift_en   (state == S_DUMP),
    .head_cnt   (hist_head)
  );

  assign dump_item.vld = (state == S_DUMP);
  assign dump_item.cnt = hist_head;
  assign dump_item.ltr = LETTER_W'(step);
  assign pass[0]       = dump_item;

  for (genvar i = 0; i < ALPHABET; i++) begin : g_cell
    if (i == ALPHABET - 1) begin : g_tail
      assign from_right[i] = '0;
    end else begin : g_body
      assign from_right[i] = held[i+1];
    end

    lfr_sort_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ins_in   (pass[i]),
      .shift_en (out_fire),
      .shift_in (from_right[i]),
      .held     (held[i]),
      .pass_out (pass[i+1])
    );
  end

  // Ranked letter and count come straight from the head cell; rank and guess follow the step counter.
  assign rank          = LETTER_W'(step);
  assign ranked_letter = held[0].ltr;
  assign count         = held[0].cnt;
  assign total         = letter_total;
  assign guess_letter  = guess_of(language, LETTER_W'(step));
  assign last_of_run   = step_end;

`ifndef SYNTHESIS
  // The chain head must be empty whenever new letters are taken.
  a_chain_empty_when_counting: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !held[0].vld)
    else $error("sort chain not empty while counting");

  // Every letter reaches the chain: the head stays filled through the whole emission.
  a_head_filled_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> held[0].vld)
    else $error("sort chain head empty during emission");

  // No entry may leave the end of the chain once results are shown.
  a_chain_settled: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !pass[ALPHABET].vld)
    else $error("entry fell off the end of the sort chain");

  // Taking the final result returns the block to counting with a clear total.
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    out_fire && last_of_run |=> in_ready && (total == '0))
    else $error("run did not end cleanly");

  // A last letter stops intake until its ranking is delivered.
  a_last_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_fire && last |=> !in_ready && !out_valid)
    else $error("input not blocked after last letter");
`endif

endmodule
